### rtl/ambisonic_ring_decoder_defines.svh
// Assertion macros for the ring decoder checker
`ifndef AMBISONIC_RING_DECODER_DEFINES_SVH
`define AMBISONIC_RING_DECODER_DEFINES_SVH

// same-cycle implication, sampled on clock, off during reset
`define ARD_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, sampled on clock, off during reset
`define ARD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/ard_pkg.sv
// Types, constants and Q1.15 arithmetic for the ring decoder
`default_nettype none
package ard_pkg;

   localparam int MAX_SPEAKERS_DEF = 64;
   localparam int IDX_W            = 6;
   localparam int CNT_W            = 7;
   localparam int CSR_IDX_W        = 3;
   localparam int CSR_DATA_W       = 16;

   typedef logic signed [15:0] q15_type;
   typedef logic signed [16:0] prod_type;
   typedef logic signed [18:0] acc_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_SPEAKER_COUNT = 3'd0,
      CSR_W_GAIN        = 3'd1,
      CSR_X_GAIN_START  = 3'd2,
      CSR_Y_GAIN_START  = 3'd3,
      CSR_COS_STEP      = 3'd4,
      CSR_SIN_STEP      = 3'd5
   } csr_index_type;

   localparam logic [CNT_W-1:0] RST_SPEAKER_COUNT = 7'd8;
   localparam q15_type RST_W_GAIN       = 16'sd23170;
   localparam q15_type RST_X_GAIN_START = 16'sd16384;
   localparam q15_type RST_Y_GAIN_START = 16'sd0;
   localparam q15_type RST_COS_STEP     = 16'sd23170;
   localparam q15_type RST_SIN_STEP     = 16'sd23170;

   typedef struct packed {
      q15_type w_sample;
      q15_type x_sample;
      q15_type y_sample;
   } ard_req_type;

   typedef struct packed {
      logic [IDX_W-1:0] speaker_index;
      q15_type          speaker_sample;
      logic             last_speaker;
   } ard_rsp_type;

   typedef struct packed {
      q15_type xg;
      q15_type yg;
   } gain_type;

   typedef struct packed {
      logic load;
      logic shift;
   } cell_ctl_type;

   // round to nearest, ties up: floor((a*b + 2^14) / 2^15)
   function automatic prod_type qmul(input q15_type a, input q15_type b);
      logic signed [31:0] p;
      p = (32'(a) * 32'(b)) + 32'sd16384;
      return prod_type'(p[31:15]);
   endfunction

   function automatic acc_type ext(input prod_type v);
      return acc_type'(v);
   endfunction

   function automatic q15_type sat16(input acc_type v);
      if (v > 19'sd32767) begin
         return 16'sh7fff;
      end else if (v < -19'sd32768) begin
         return 16'sh8000;
      end
      return q15_type'(v[15:0]);
   endfunction

endpackage
`default_nettype wire

### rtl/ambisonic_ring_decoder.sv
// Top level: first-order horizontal B-format decoder for a ring of speakers
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall  w, x, y samples
//   rsp      out  rsp_valid/rsp_stall  speaker index, sample, last flag
//   csr      in   csr_wr_en            index, data
//
// An item yields one result per cycle while the output is not stalled, one for each of
// its n speakers (8 by default), set by the single result port; the next item starts
// right after the last speaker. The item is registered, then passes the product stage,
// the sum stage and the output register. After reset and after each register write the
// input stalls while the gain chain of cells settles. A stalled output freezes the pipe
// once the skid slot holds an item.
`default_nettype none
module ambisonic_ring_decoder #(
   parameter int MAX_SPEAKERS = ard_pkg::MAX_SPEAKERS_DEF
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output      logic                                 req_stall,
   input  wire ard_pkg::ard_req_type                 req_data,
   output      logic                                 rsp_valid,
   input  wire logic                                 rsp_stall,
   output      ard_pkg::ard_rsp_type                 rsp_data,
   input  wire logic                                 csr_wr_en,
   input  wire logic [ard_pkg::CSR_IDX_W-1:0]        csr_index,
   input  wire logic [ard_pkg::CSR_DATA_W-1:0]       csr_wdata
);
   import ard_pkg::*;

   localparam int SETTLE_CYCLES = 2 * MAX_SPEAKERS;
   localparam int SETTLE_W      = $clog2(SETTLE_CYCLES + 1);
   localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_SPEAKERS);

   // registers
   logic [CNT_W-1:0] count_ff, count_in;
   q15_type w_gain_ff, w_gain_in, x_start_ff, x_start_in, y_start_ff, y_start_in;
   q15_type cos_ff, cos_in, sin_ff, sin_in;
   logic [SETTLE_W-1:0] settle_ff, settle_in;

   always_comb begin
      count_in   = count_ff;
      w_gain_in  = w_gain_ff;
      x_start_in = x_start_ff;
      y_start_in = y_start_ff;
      cos_in     = cos_ff;
      sin_in     = sin_ff;
      settle_in  = (settle_ff != '0) ? settle_ff - 1'b1 : settle_ff;
      if (csr_wr_en) begin
         settle_in = SETTLE_W'(SETTLE_CYCLES);
         unique case (csr_index)
            CSR_SPEAKER_COUNT: count_in   = csr_wdata[CNT_W-1:0];
            CSR_W_GAIN:        w_gain_in  = q15_type'(csr_wdata);
            CSR_X_GAIN_START:  x_start_in = q15_type'(csr_wdata);
            CSR_Y_GAIN_START:  y_start_in = q15_type'(csr_wdata);
            CSR_COS_STEP:      cos_in     = q15_type'(csr_wdata);
            CSR_SIN_STEP:      sin_in     = q15_type'(csr_wdata);
            default:           count_in   = count_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= RST_SPEAKER_COUNT;
         w_gain_ff  <= RST_W_GAIN;
         x_start_ff <= RST_X_GAIN_START;
         y_start_ff <= RST_Y_GAIN_START;
         cos_ff     <= RST_COS_STEP;
         sin_ff     <= RST_SIN_STEP;
         settle_ff  <= SETTLE_W'(SETTLE_CYCLES);
      end else begin
         count_ff   <= count_in;
         w_gain_ff  <= w_gain_in;
         x_start_ff <= x_start_in;
         y_start_ff <= y_start_in;
         cos_ff     <= cos_in;
         sin_ff     <= sin_in;
         settle_ff  <= settle_in;
      end
   end

   // sequencer
   logic             adv;
   logic             cur_valid_ff, cur_valid_in;
   ard_req_type      cur_ff, cur_in;
   logic [IDX_W-1:0] k_ff, k_in;
   logic [CNT_W-1:0] n_eff;
   logic             last, issue, last_issue, can_take, accept;
   cell_ctl_type     ctl;

   always_comb begin
      n_eff        = (count_ff > MAX_CNT) ? MAX_CNT : count_ff;
      last         = ({1'b0, k_ff} + 7'd1) == n_eff;
      issue        = cur_valid_ff && adv;
      last_issue   = issue && last;
      can_take     = (settle_ff == '0) && (!cur_valid_ff || last_issue);
      accept       = req_valid && can_take;
      ctl.load     = accept;
      ctl.shift    = issue && !accept;
      cur_valid_in = cur_valid_ff;
      cur_in       = cur_ff;
      k_in         = k_ff;
      if (accept) begin
         cur_valid_in = n_eff != '0;
         cur_in       = req_data;
         k_in         = '0;
      end else if (issue) begin
         cur_valid_in = !last;
         k_in         = k_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_valid_ff <= 1'b0;
      end else begin
         cur_valid_ff <= cur_valid_in;
      end
      cur_ff <= cur_in;
      k_ff   <= k_in;
   end

   assign req_stall = !can_take;

   // chain of cells
   gain_type g_chain [MAX_SPEAKERS+1];
   gain_type s_line  [MAX_SPEAKERS];
   gain_type s_src   [MAX_SPEAKERS];

   assign g_chain[0] = '{xg: x_start_ff, yg: y_start_ff};

   for (genvar i = 0; i < MAX_SPEAKERS; i++) begin : g_cell
      if (i < MAX_SPEAKERS - 1) begin : g_mid
         assign s_src[i] = s_line[i+1];
      end else begin : g_end
         assign s_src[i] = g_chain[MAX_SPEAKERS];
      end
      ard_cell u_cell (
         .clock    (clock),
         .g_in     (g_chain[i]),
         .cos_step (cos_ff),
         .sin_step (sin_ff),
         .s_next   (s_src[i]),
         .ctl      (ctl),
         .g_out    (g_chain[i+1]),
         .s_out    (s_line[i])
      );
   end

   // product and sum stages
   logic             p1_valid_ff, p1_valid_in;
   prod_type         p1_w_ff, p1_w_in, p1_x_ff, p1_x_in, p1_y_ff, p1_y_in;
   logic [IDX_W-1:0] p1_idx_ff;
   logic             p1_last_ff;
   logic             p2_valid_ff, p2_valid_in;
   ard_rsp_type      p2_ff, p2_in;

   always_comb begin
      p1_w_in     = qmul(cur_ff.w_sample, w_gain_ff);
      p1_x_in     = qmul(cur_ff.x_sample, s_line[0].xg);
      p1_y_in     = qmul(cur_ff.y_sample, s_line[0].yg);
      p1_valid_in = adv ? issue : p1_valid_ff;
      p2_valid_in = adv ? p1_valid_ff : p2_valid_ff;
      p2_in.speaker_index  = p1_idx_ff;
      p2_in.speaker_sample = sat16(ext(p1_w_ff) + ext(p1_x_ff) + ext(p1_y_ff));
      p2_in.last_speaker   = p1_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
         p2_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= p1_valid_in;
         p2_valid_ff <= p2_valid_in;
      end
      if (adv) begin
         p1_w_ff    <= p1_w_in;
         p1_x_ff    <= p1_x_in;
         p1_y_ff    <= p1_y_in;
         p1_idx_ff  <= k_ff;
         p1_last_ff <= last;
         p2_ff      <= p2_in;
      end
   end

   ard_out_buf u_out (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (p2_valid_ff),
      .in_data   (p2_ff),
      .in_ready  (adv),
      .out_valid (rsp_valid),
      .out_data  (rsp_data),
      .out_stall (rsp_stall)
   );

endmodule
`default_nettype wire

### rtl/ard_cell.sv
// One ring cell: rotates the gain pair to the next speaker and holds one working gain slot
`default_nettype none
module ard_cell (
   input  wire logic                  clock,
   input  wire ard_pkg::gain_type     g_in,
   input  wire ard_pkg::q15_type      cos_step,
   input  wire ard_pkg::q15_type      sin_step,
   input  wire ard_pkg::gain_type     s_next,
   input  wire ard_pkg::cell_ctl_type ctl,
   output      ard_pkg::gain_type     g_out,
   output      ard_pkg::gain_type     s_out
);
   import ard_pkg::*;

   prod_type xc_ff, ys_ff, yc_ff, xs_ff;
   prod_type xc_in, ys_in, yc_in, xs_in;
   gain_type g_ff, g_in_nx;
   gain_type s_ff, s_in;

   always_comb begin
      xc_in      = qmul(g_in.xg, cos_step);
      ys_in      = qmul(g_in.yg, sin_step);
      yc_in      = qmul(g_in.yg, cos_step);
      xs_in      = qmul(g_in.xg, sin_step);
      g_in_nx.xg = sat16(ext(xc_ff) + ext(ys_ff));
      g_in_nx.yg = sat16(ext(yc_ff) - ext(xs_ff));
      if (ctl.load) begin
         s_in = g_in;
      end else if (ctl.shift) begin
         s_in = s_next;
      end else begin
         s_in = s_ff;
      end
   end

   always_ff @(posedge clock) begin
      xc_ff <= xc_in;
      ys_ff <= ys_in;
      yc_ff <= yc_in;
      xs_ff <= xs_in;
      g_ff  <= g_in_nx;
      s_ff  <= s_in;
   end

   assign g_out = g_ff;
   assign s_out = s_ff;

endmodule
`default_nettype wire

### rtl/ard_out_buf.sv
// Output register with skid slot for the result channel
`default_nettype none
module ard_out_buf (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 in_valid,
   input  wire ard_pkg::ard_rsp_type in_data,
   output      logic                 in_ready,
   output      logic                 out_valid,
   output      ard_pkg::ard_rsp_type out_data,
   input  wire logic                 out_stall
);
   import ard_pkg::*;

   logic        out_valid_ff, out_valid_in;
   logic        skid_valid_ff, skid_valid_in;
   ard_rsp_type out_ff, out_in;
   ard_rsp_type skid_ff, skid_in;
   logic        take, in_fire;

   always_comb begin
      take          = out_valid_ff && !out_stall;
      in_fire       = in_valid && !skid_valid_ff;
      out_valid_in  = out_valid_ff;
      out_in        = out_ff;
      skid_valid_in = skid_valid_ff;
      skid_in       = skid_ff;
      if (skid_valid_ff) begin
         if (take) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || take) begin
         out_valid_in = in_fire;
         if (in_fire) begin
            out_in = in_data;
         end
      end else if (in_fire) begin
         skid_valid_in = 1'b1;
         skid_in       = in_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign in_ready  = !skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_data  = out_ff;

endmodule
`default_nettype wire

### rtl/ard_checker.sv
// Port-level checks for the ring decoder, bound to the top level
`default_nettype none
`include "ambisonic_ring_decoder_defines.svh"
module ard_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                req_stall,
   input wire logic                                rsp_valid,
   input wire logic                                rsp_stall,
   input wire ard_pkg::ard_rsp_type                rsp_data,
   input wire logic                                csr_wr_en
);
   import ard_pkg::*;

   `ARD_ASSERT_NEXT(a_rsp_hold, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_data), "rsp item changed while stalled")
   `ARD_ASSERT_NOW(a_reset_stall, $fell(reset), req_stall, "input open right after reset")
   `ARD_ASSERT_NEXT(a_csr_stall, csr_wr_en, req_stall, "input open right after register write")
   `ARD_ASSERT_NOW(a_index_step, (rsp_valid && !rsp_stall && !rsp_data.last_speaker) ##1 rsp_valid, rsp_data.speaker_index == $past(rsp_data.speaker_index) + 6'd1, "speaker index skipped")

endmodule

bind ambisonic_ring_decoder ard_checker u_ard_checker (.*);
`default_nettype wire
